// File: src/atr_pkg.sv
// shared types, constants and the response string table for the at response line recognizer
// no dependencies; imported by every module of the block
`default_nettype none

package atr_pkg;

    // line and table sizing
    localparam int MAX_LINE_DEF    = 100;
    localparam int TABLE_ROWS      = 24;
    localparam int TABLE_ENTRIES   = 24;
    localparam int ENTRY_MAX_LEN   = 28;
    localparam int ACTIVE_ROWS     = (TABLE_ENTRIES < TABLE_ROWS) ? TABLE_ENTRIES : TABLE_ROWS;
    localparam int ROW_W           = $clog2(TABLE_ROWS);
    localparam int STR_CHARS       = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // field widths
    localparam int BYTE_W = 8;
    localparam int CODE_W = 5;
    localparam int LEN_W  = 7;
    localparam int POS_CALC_W = 9;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CODE_W-1:0] NO_MATCH_CODE = CODE_W'(TABLE_ENTRIES % 32);

    // special characters
    localparam logic [BYTE_W-1:0] RESTART_CHAR = 8'h7E;
    localparam logic [BYTE_W-1:0] CR_CHAR      = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_CHAR      = 8'h0A;

    // byte class set by the front end
    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_CR,
        KIND_LF,
        KIND_RESTART
    } byte_kind_t;

    typedef struct packed {
        byte_kind_t        kind;
        logic [BYTE_W-1:0] value;
    } rx_item_t;

    // response strings, right justified, last character in the low byte, cr as octal 015
    localparam logic [8*STR_CHARS-1:0] RESP_STR [TABLE_ROWS] = '{
        "OK\015",
        "ERROR\015",
        "\015",
        "^RSSILVL:0\015",
        "^RSSILVL:20\015",
        "^RSSILVL:40\015",
        "^RSSILVL:60\015",
        "^RSSILVL:80\015",
        "^RSSILVL:99\015",
        "^MODE:0\015",
        "^MODE:2\015",
        "AT^IPINIT\015",
        "AT^IPINIT?\015",
        "^IPINIT:0",
        "^IPINIT:1",
        "AT^IPOPEN=",
        "+CME ERROR:",
        "AT^IPSEND=3,",
        "AT^IPENTRANS=1\015",
        "^SYSINFO:",
        "^DSDORMANT: 1\015",
        "^IPSTATE: 1,0,remote close\015",
        ">\015",
        "^HCMGSS:"
    };

    localparam logic [5:0] RESP_LEN [TABLE_ROWS] = '{
        6'd3, 6'd6, 6'd1, 6'd11, 6'd12, 6'd12, 6'd12, 6'd12, 6'd12, 6'd8, 6'd8, 6'd10,
        6'd11, 6'd9, 6'd9, 6'd10, 6'd11, 6'd12, 6'd15, 6'd9, 6'd14, 6'd27, 6'd2, 6'd8
    };

    // character of a response string at a line position, zero past its end
    function automatic logic [BYTE_W-1:0] table_char(input logic [ROW_W-1:0] row,
                                                     input logic [POS_CALC_W-1:0] pos);
        logic [POS_CALC_W-1:0] len;
        logic [POS_CALC_W-1:0] idx;
        len = POS_CALC_W'(RESP_LEN[row]);
        idx = len - pos - POS_CALC_W'(1);
        if (pos >= POS_CALC_W'(ENTRY_MAX_LEN) || pos >= len)
        begin
            return '0;
        end
        return RESP_STR[row][8*idx +: 8];
    endfunction

endpackage

`default_nettype wire

// File: src/atr_front.sv
// front end: takes receive bytes and tags each with its class
// depends on atr_pkg
`default_nettype none

module atr_front
    import atr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    output      logic                  push,
    output      rx_item_t              push_item,
    input  wire logic                  queue_ready
);

    logic [BYTE_W-1:0] rx_byte;

    assign rx_byte = s_tdata[BYTE_W-1:0];

    // accept whenever the queue has room
    assign s_tready = queue_ready;
    assign push     = s_tvalid && queue_ready;

    // classify the byte
    always_comb
    begin
        push_item.value = rx_byte;
        unique case (rx_byte)
            RESTART_CHAR:
            begin
                push_item.kind = KIND_RESTART;
            end
            CR_CHAR:
            begin
                push_item.kind = KIND_CR;
            end
            LF_CHAR:
            begin
                push_item.kind = KIND_LF;
            end
            default:
            begin
                push_item.kind = KIND_DATA;
            end
        endcase
    end

    // classes must agree with the byte
    a_restart_class: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_item.kind == KIND_RESTART |-> push_item.value == RESTART_CHAR)
        else $error("restart class on wrong byte");
    a_lf_class: assert property (@(posedge clk) disable iff (!rst_n)
        push && (s_tdata[BYTE_W-1:0] == LF_CHAR) |-> push_item.kind == KIND_LF)
        else $error("line feed not classified");
    a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> s_tready)
        else $error("push without ready");

endmodule

`default_nettype wire

// File: src/atr_queue.sv
// short first-in first-out queue of classified bytes between front and back
// depends on atr_pkg
`default_nettype none

module atr_queue
    import atr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire rx_item_t push_item,
    output      logic     ready,
    output      logic     valid,
    output      rx_item_t head_item,
    input  wire logic     pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rx_item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_pop;

    assign ready     = count_reg != CNT_W'(QUEUE_DEPTH);
    assign valid     = count_reg != '0;
    assign head_item = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("queue overflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_pop_drain: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !push && count_reg == CNT_W'(1) |=> !valid)
        else $error("queue not empty after last pop");

endmodule

`default_nettype wire

// File: src/atr_back.sv
// back end: on-the-fly string match, line tracking and the result register
// depends on atr_pkg
`default_nettype none

module atr_back
    import atr_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    input  wire rx_item_t               item,
    output      logic                   pop,
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata    // [4:0] response_code, [11:5] line_length
);

    localparam int POS_W = $clog2(MAX_LINE);

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [ACTIVE_ROWS-1:0] alive_reg, alive_next;
    logic [ACTIVE_ROWS-1:0] done_reg, done_next;
    logic                   prev_cr_reg, prev_cr_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]      out_code_reg, code_calc;
    logic [LEN_W-1:0]       out_len_reg;
    logic [ACTIVE_ROWS-1:0] alive_match, done_match;
    logic [POS_CALC_W-1:0]  pos_wide, pos_inc;
    logic                   line_end, out_free, out_load;
    logic [BYTE_W-1:0]      cur_char, nxt_char;

    assign pos_wide = POS_CALC_W'(pos_reg);
    assign pos_inc  = pos_wide + POS_CALC_W'(1);
    assign line_end = (item.kind == KIND_LF) && prev_cr_reg && (pos_reg != '0);
    assign out_free = !out_valid_reg || m_tready;
    assign pop      = item_valid && (!line_end || out_free);
    assign out_load = pop && line_end;

    // match every live string against the byte at this position
    always_comb
    begin
        alive_match = alive_reg;
        done_match  = done_reg;
        cur_char    = '0;
        nxt_char    = '0;
        for (int i = 0; i < ACTIVE_ROWS; i++)
        begin
            cur_char = table_char(ROW_W'(i), pos_wide);
            nxt_char = table_char(ROW_W'(i), pos_inc);
            if (alive_reg[i] && !done_reg[i])
            begin
                if (cur_char == '0 || cur_char != item.value)
                begin
                    alive_match[i] = 1'b0;
                end
                else if (nxt_char == '0)
                begin
                    done_match[i] = 1'b1;
                end
            end
        end
    end

    // first fully matched string wins
    always_comb
    begin
        code_calc = NO_MATCH_CODE;
        for (int i = ACTIVE_ROWS - 1; i >= 0; i--)
        begin
            if (done_match[i])
            begin
                code_calc = CODE_W'(i);
            end
        end
    end

    // line state update
    always_comb
    begin
        pos_next     = pos_reg;
        alive_next   = alive_reg;
        done_next    = done_reg;
        prev_cr_next = prev_cr_reg;
        if (pop)
        begin
            if (item.kind == KIND_RESTART || line_end || pos_inc >= POS_CALC_W'(MAX_LINE))
            begin
                pos_next     = '0;
                alive_next   = '1;
                done_next    = '0;
                prev_cr_next = 1'b0;
            end
            else
            begin
                pos_next     = pos_inc[POS_W-1:0];
                alive_next   = alive_match;
                done_next    = done_match;
                prev_cr_next = (item.kind == KIND_CR);
            end
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            alive_reg     <= '1;
            done_reg      <= '0;
            prev_cr_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            alive_reg     <= alive_next;
            done_reg      <= done_next;
            prev_cr_reg   <= prev_cr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_code_reg <= code_calc;
            out_len_reg  <= pos_inc[LEN_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - CODE_W - LEN_W)'(0), out_len_reg, out_code_reg};

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        POS_CALC_W'(pos_reg) < POS_CALC_W'(MAX_LINE))
        else $error("line position past maximum");
    a_cr_not_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        prev_cr_reg |-> pos_reg != '0)
        else $error("carriage return flag at line start");
    a_done_alive: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg & ~alive_reg) == '0)
        else $error("matched string not alive");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid && m_tdata[CODE_W-1:0] <= CODE_W'(TABLE_ENTRIES % 32))
        else $error("result not presented after line end");

endmodule

`default_nettype wire

// File: src/at_response_line_recognizer_core.sv
// top level of the at response line recognizer: front end, byte queue, matcher back end
// depends on atr_pkg, atr_front, atr_queue, atr_back
//
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid / s_tready  s_tdata[7:0] rx_byte
//   m_*      out        m_tvalid / m_tready  m_tdata[4:0] response_code, [11:5] line_length
//
// one received byte per cycle sustained while the result is not stalled; each byte passes
// front end, a two-slot queue and the matcher, and the result register is loaded when the
// closing line feed leaves the queue. all 24 strings are compared in parallel against a
// constant table. reset clears the queue, the line state and the result register at once.
// a stalled result holds the matcher only on the next line end; later bytes wait in the queue.
`default_nettype none

module at_response_line_recognizer_core
    import atr_pkg::*;
#(
    parameter int MAX_LINE    = MAX_LINE_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata    // [4:0] response_code, [11:5] line_length
);

    logic     push, queue_ready, queue_valid, pop;
    rx_item_t push_item, head_item;

    atr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .push        (push),
        .push_item   (push_item),
        .queue_ready (queue_ready)
    );

    atr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .ready     (queue_ready),
        .valid     (queue_valid),
        .head_item (head_item),
        .pop       (pop)
    );

    atr_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item       (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire
